// File: rtl/bslc_pkg.sv
// ----------------------------------------------------------------------------
// bslc_pkg
// Types and constants shared by the button sequence lock controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bslc_pkg;

  // Configuration register data width, register index width and tap count width.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TAP_W     = 4;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TMO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TAPS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_TAPS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_ON     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_OFF  = 3'd6;

  // Register values after reset.
  localparam logic [CFG_W-1:0] DEF_DEBOUNCE    = 16'd50;
  localparam logic [CFG_W-1:0] DEF_HOLD        = 16'd10000;
  localparam logic [CFG_W-1:0] DEF_TAP_TMO     = 16'd5000;
  localparam logic [TAP_W-1:0] DEF_LOCK_TAPS   = 4'd5;
  localparam logic [TAP_W-1:0] DEF_UNLOCK_TAPS = 4'd3;
  localparam logic [CFG_W-1:0] DEF_RED_ON      = 16'd5000;
  localparam logic [CFG_W-1:0] DEF_GREEN_OFF   = 16'd1500;

  // Power key pulse pattern: counter width and phase boundaries.
  localparam int unsigned PAT_W = 12;
  localparam logic [PAT_W-1:0] PAT_OFF1_AT = 12'd2000;
  localparam logic [PAT_W-1:0] PAT_ON2_AT  = 12'd2200;
  localparam logic [PAT_W-1:0] PAT_OFF2_AT = 12'd2700;
  localparam logic [PAT_W-1:0] PAT_ON3_AT  = 12'd2900;
  localparam logic [PAT_W-1:0] PAT_END_AT  = 12'd3200;

  // Pattern phases; idle means no pattern is running.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ON1  = 3'd1,
    PH_OFF1 = 3'd2,
    PH_ON2  = 3'd3,
    PH_OFF2 = 3'd4,
    PH_TAIL = 3'd5
  } pat_phase_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] tap_timeout_ticks;
    logic [TAP_W-1:0] lock_tap_count;
    logic [TAP_W-1:0] unlock_tap_count;
    logic [CFG_W-1:0] red_on_ticks;
    logic [CFG_W-1:0] green_off_delay_ticks;
  } cfg_t;

  // Debounced button level and its edges for the current tick.
  typedef struct packed {
    logic stable;
    logic pressed;
    logic released;
  } btn_evt_t;

  // Lock sequencer status after the current tick.
  typedef struct packed {
    logic             locked;
    logic             red_led;
    logic             window;
    logic [TAP_W-1:0] taps;
  } lock_stat_t;

endpackage

`default_nettype wire

// File: rtl/bslc_channels.sv
// ----------------------------------------------------------------------------
// bslc channels
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bslc_tick_if;
  logic valid;
  logic ready;
  logic button_pressed;
  logic power_led_on;

  modport source (output valid, output button_pressed, output power_led_on, input ready);
  modport sink   (input valid, input button_pressed, input power_led_on, output ready);
endinterface

interface bslc_result_if;
  logic       valid;
  logic       ready;
  logic       power_key_level;
  logic       red_led;
  logic       locked_flag;
  logic       green_level;
  logic       tap_window;
  logic [3:0] taps_seen;

  modport source (output valid, output power_key_level, output red_led, output locked_flag,
                  output green_level, output tap_window, output taps_seen, input ready);
  modport sink   (input valid, input power_key_level, input red_led, input locked_flag,
                  input green_level, input tap_window, input taps_seen, output ready);
endinterface

`default_nettype wire

// File: rtl/bslc_input_cond.sv
// ----------------------------------------------------------------------------
// bslc_input_cond
// Button debouncer with edge detection, and off-delay filter for power status.
// ----------------------------------------------------------------------------
`default_nettype none

module bslc_input_cond #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire bslc_pkg::cfg_t    cfg,
  input  wire logic              button_raw,
  input  wire logic              power_raw,
  output bslc_pkg::btn_evt_t     btn,
  output logic                   green_next
);

  localparam int unsigned CW = (TIMER_BITS > bslc_pkg::CFG_W) ? TIMER_BITS : bslc_pkg::CFG_W;

  logic                  sample_prev;
  logic [TIMER_BITS-1:0] debounce_count;
  logic [TIMER_BITS-1:0] debounce_count_next;
  logic                  button_stable;
  logic                  button_stable_next;
  logic                  green_state;
  logic                  green_off_active;
  logic                  green_off_active_next;
  logic [TIMER_BITS-1:0] green_off_count;
  logic [TIMER_BITS-1:0] green_off_count_next;

  // Debounce: the raw level is taken once it has stayed put long enough.
  always_comb begin
    if (button_raw != sample_prev) begin
      debounce_count_next = '0;
    end else if (&debounce_count) begin
      debounce_count_next = debounce_count;
    end else begin
      debounce_count_next = debounce_count + 1'b1;
    end
    if (CW'(debounce_count_next) >= CW'(cfg.debounce_ticks)) begin
      button_stable_next = button_raw;
    end else begin
      button_stable_next = button_stable;
    end
  end

  assign btn.stable   = button_stable_next;
  assign btn.pressed  = button_stable_next & ~button_stable;
  assign btn.released = ~button_stable_next & button_stable;

  // Green filter: rises at once, falls after a run of unpowered ticks.
  always_comb begin
    green_next            = green_state;
    green_off_active_next = green_off_active;
    green_off_count_next  = green_off_count;
    if (power_raw) begin
      green_next            = 1'b1;
      green_off_active_next = 1'b0;
      green_off_count_next  = '0;
    end else if (green_state) begin
      if (!green_off_active) begin
        green_off_active_next = 1'b1;
        green_off_count_next  = '0;
      end else begin
        if (!(&green_off_count)) begin
          green_off_count_next = green_off_count + 1'b1;
        end
        if (CW'(green_off_count_next) >= CW'(cfg.green_off_delay_ticks)) begin
          green_next = 1'b0;
        end
      end
    end
  end

  // State update on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_prev      <= 1'b0;
      debounce_count   <= '0;
      button_stable    <= 1'b0;
      green_state      <= 1'b0;
      green_off_active <= 1'b0;
      green_off_count  <= '0;
    end else if (step) begin
      sample_prev      <= button_raw;
      debounce_count   <= debounce_count_next;
      button_stable    <= button_stable_next;
      green_state      <= green_next;
      green_off_active <= green_off_active_next;
      green_off_count  <= green_off_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bslc_lock_seq.sv
// ----------------------------------------------------------------------------
// bslc_lock_seq
// Hold qualification, tap window, tap counting, lock state and red LED timer.
// ----------------------------------------------------------------------------
`default_nettype none

module bslc_lock_seq #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire bslc_pkg::cfg_t     cfg,
  input  wire bslc_pkg::btn_evt_t btn,
  output bslc_pkg::lock_stat_t    stat
);

  localparam int unsigned CW = (TIMER_BITS > bslc_pkg::CFG_W) ? TIMER_BITS : bslc_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic                           hold_armed;
  logic                           hold_armed_next;
  logic [TIMER_BITS-1:0]          hold_count;
  logic [TIMER_BITS-1:0]          hold_count_next;
  logic                           hold_ok;
  logic                           hold_ok_next;
  logic                           window_open;
  logic                           window_open_next;
  logic [TIMER_BITS-1:0]          window_count;
  logic [TIMER_BITS-1:0]          window_count_next;
  logic [bslc_pkg::TAP_W-1:0]     tap_total;
  logic [bslc_pkg::TAP_W-1:0]     tap_total_next;
  logic                           lock_state;
  logic                           lock_state_next;
  logic [TIMER_BITS-1:0]          red_remaining;
  logic [TIMER_BITS-1:0]          red_remaining_next;
  logic [TIMER_BITS-1:0]          red_reload;
  logic                           opened;

  // The red on time is clipped to what the timer can hold.
  assign red_reload = (CW'(cfg.red_on_ticks) > CW'(TMAX)) ? TMAX
                                                           : TIMER_BITS'(cfg.red_on_ticks);

  // One tick of the sequencer, in the order the conditions are defined.
  always_comb begin
    hold_armed_next    = hold_armed;
    hold_count_next    = hold_count;
    hold_ok_next       = hold_ok;
    window_open_next   = window_open;
    window_count_next  = window_count;
    tap_total_next     = tap_total;
    lock_state_next    = lock_state;
    red_remaining_next = red_remaining;
    opened             = 1'b0;

    if (red_remaining != '0) begin
      red_remaining_next = red_remaining - 1'b1;
    end

    // Hold tracking.
    if (hold_armed && !(&hold_count)) begin
      hold_count_next = hold_count + 1'b1;
    end
    if (btn.pressed && !window_open_next) begin
      hold_armed_next = 1'b1;
      hold_count_next = '0;
      hold_ok_next    = 1'b0;
    end
    if (btn.stable && hold_armed_next && !window_open_next && !hold_ok_next &&
        CW'(hold_count_next) >= CW'(cfg.hold_ticks)) begin
      hold_ok_next = 1'b1;
    end
    if (btn.released && hold_ok_next && !window_open_next) begin
      window_open_next  = 1'b1;
      window_count_next = '0;
      tap_total_next    = '0;
      opened            = 1'b1;
    end
    if (btn.released && !window_open_next) begin
      hold_armed_next = 1'b0;
      hold_ok_next    = 1'b0;
    end

    // Tap window: time out, or count a tap and check for a lock change.
    if (window_open_next) begin
      if (!opened && !(&window_count_next)) begin
        window_count_next = window_count_next + 1'b1;
      end
      if (CW'(window_count_next) > CW'(cfg.tap_timeout_ticks)) begin
        window_open_next = 1'b0;
        tap_total_next   = '0;
        hold_ok_next     = 1'b0;
      end else if (btn.pressed) begin
        if (!(&tap_total_next)) begin
          tap_total_next = tap_total_next + 1'b1;
        end
        if (!lock_state && tap_total_next >= cfg.lock_tap_count) begin
          lock_state_next    = 1'b1;
          red_remaining_next = red_reload;
          window_open_next   = 1'b0;
          tap_total_next     = '0;
          hold_ok_next       = 1'b0;
        end else if (lock_state && tap_total_next >= cfg.unlock_tap_count) begin
          lock_state_next    = 1'b0;
          red_remaining_next = '0;
          window_open_next   = 1'b0;
          tap_total_next     = '0;
          hold_ok_next       = 1'b0;
        end
      end
    end

    // Every press while locked restarts the red timer.
    if (lock_state_next && btn.pressed) begin
      red_remaining_next = red_reload;
    end
  end

  assign stat.locked  = lock_state_next;
  assign stat.red_led = lock_state_next && (red_remaining_next != '0);
  assign stat.window  = window_open_next;
  assign stat.taps    = tap_total_next;

  // State update on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_armed    <= 1'b0;
      hold_count    <= '0;
      hold_ok       <= 1'b0;
      window_open   <= 1'b0;
      window_count  <= '0;
      tap_total     <= '0;
      lock_state    <= 1'b0;
      red_remaining <= '0;
    end else if (step) begin
      hold_armed    <= hold_armed_next;
      hold_count    <= hold_count_next;
      hold_ok       <= hold_ok_next;
      window_open   <= window_open_next;
      window_count  <= window_count_next;
      tap_total     <= tap_total_next;
      lock_state    <= lock_state_next;
      red_remaining <= red_remaining_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bslc_key_pattern.sv
// ----------------------------------------------------------------------------
// bslc_key_pattern
// Power key drive: pulse pattern while locked and powered, button follower
// while unlocked.
// ----------------------------------------------------------------------------
`default_nettype none

module bslc_key_pattern (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic locked,
  input  wire logic power_raw,
  input  wire logic button_stable,
  output logic      key_level_next
);

  bslc_pkg::pat_phase_t          phase;
  bslc_pkg::pat_phase_t          phase_next;
  logic [bslc_pkg::PAT_W-1:0]    pattern_count;
  logic [bslc_pkg::PAT_W-1:0]    pattern_count_next;
  logic [bslc_pkg::PAT_W-1:0]    count_run;
  logic                          key_level;

  // The pattern counter runs whenever a pattern is in progress, saturating.
  always_comb begin
    if (phase != bslc_pkg::PH_IDLE && !(&pattern_count)) begin
      count_run = pattern_count + 1'b1;
    end else begin
      count_run = pattern_count;
    end
  end

  // Next phase: at most one phase step per tick.
  always_comb begin
    phase_next         = phase;
    pattern_count_next = count_run;
    if (locked && power_raw) begin
      if (phase == bslc_pkg::PH_IDLE) begin
        phase_next         = bslc_pkg::PH_ON1;
        pattern_count_next = '0;
      end else begin
        case (phase)
          bslc_pkg::PH_ON1: begin
            if (count_run >= bslc_pkg::PAT_OFF1_AT) phase_next = bslc_pkg::PH_OFF1;
          end
          bslc_pkg::PH_OFF1: begin
            if (count_run >= bslc_pkg::PAT_ON2_AT) phase_next = bslc_pkg::PH_ON2;
          end
          bslc_pkg::PH_ON2: begin
            if (count_run >= bslc_pkg::PAT_OFF2_AT) phase_next = bslc_pkg::PH_OFF2;
          end
          bslc_pkg::PH_OFF2: begin
            if (count_run >= bslc_pkg::PAT_ON3_AT) phase_next = bslc_pkg::PH_TAIL;
          end
          bslc_pkg::PH_TAIL: begin
            if (count_run >= bslc_pkg::PAT_END_AT) phase_next = bslc_pkg::PH_IDLE;
          end
          default: phase_next = phase;
        endcase
      end
    end else if (!locked) begin
      phase_next = bslc_pkg::PH_IDLE;
    end
  end

  // Key level: follows the button when unlocked, holds when locked without
  // power, and otherwise takes the level of the phase being entered.
  always_comb begin
    key_level_next = key_level;
    if (!locked) begin
      key_level_next = button_stable;
    end else if (power_raw) begin
      case (phase_next)
        bslc_pkg::PH_ON1, bslc_pkg::PH_ON2, bslc_pkg::PH_TAIL: key_level_next = 1'b1;
        bslc_pkg::PH_OFF1, bslc_pkg::PH_OFF2:                  key_level_next = 1'b0;
        default:                                               key_level_next = key_level;
      endcase
    end
  end

  // State update on each accepted tick; the key rests at the ON level.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bslc_pkg::PH_IDLE;
      pattern_count <= '0;
      key_level     <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      pattern_count <= pattern_count_next;
      key_level     <= key_level_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/button_sequence_lock_controller_unit.sv
// ----------------------------------------------------------------------------
// button_sequence_lock_controller_unit
// Tap-sequence lock controller advanced by one tick item per transaction.
//
//   Channel   Direction  Payload                                   Handshake
//   in_ch     sink       button_pressed, power_led_on              valid/ready
//   out_ch    source     power_key_level, red_led, locked_flag,    valid/ready
//                        green_level, tap_window, taps_seen
//   cfg       write      cfg_wr_en, cfg_index, cfg_wdata           enable only
//
// One tick is taken per cycle while in_ch.ready is high; its result appears
// in the output register on the next cycle, where it waits until out_ch.ready.
// in_ch.ready is high whenever the output register is empty or being read, so
// a stalled result only holds the input back while it is itself unread.
// Synchronous reset loads the register defaults, clears all sequencer state
// and sets the power key to its ON level.
// ----------------------------------------------------------------------------
`default_nettype none

module button_sequence_lock_controller_unit #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  bslc_tick_if.sink                             in_ch,
  bslc_result_if.source                         out_ch,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bslc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bslc_pkg::CFG_W-1:0]       cfg_wdata
);

  bslc_pkg::cfg_t       cfg;
  bslc_pkg::btn_evt_t   btn;
  bslc_pkg::lock_stat_t stat;
  logic                 green_next;
  logic                 key_next;
  logic                 step;
  logic                 out_valid;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks        <= bslc_pkg::DEF_DEBOUNCE;
      cfg.hold_ticks            <= bslc_pkg::DEF_HOLD;
      cfg.tap_timeout_ticks     <= bslc_pkg::DEF_TAP_TMO;
      cfg.lock_tap_count        <= bslc_pkg::DEF_LOCK_TAPS;
      cfg.unlock_tap_count      <= bslc_pkg::DEF_UNLOCK_TAPS;
      cfg.red_on_ticks          <= bslc_pkg::DEF_RED_ON;
      cfg.green_off_delay_ticks <= bslc_pkg::DEF_GREEN_OFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bslc_pkg::CFG_DEBOUNCE:    cfg.debounce_ticks        <= cfg_wdata;
        bslc_pkg::CFG_HOLD:        cfg.hold_ticks            <= cfg_wdata;
        bslc_pkg::CFG_TAP_TMO:     cfg.tap_timeout_ticks     <= cfg_wdata;
        bslc_pkg::CFG_LOCK_TAPS:   cfg.lock_tap_count        <= cfg_wdata[bslc_pkg::TAP_W-1:0];
        bslc_pkg::CFG_UNLOCK_TAPS: cfg.unlock_tap_count      <= cfg_wdata[bslc_pkg::TAP_W-1:0];
        bslc_pkg::CFG_RED_ON:      cfg.red_on_ticks          <= cfg_wdata;
        bslc_pkg::CFG_GREEN_OFF:   cfg.green_off_delay_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: accept while the output register is free or being emptied.
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign step         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  bslc_input_cond #(
    .TIMER_BITS (TIMER_BITS)
  ) u_input_cond (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cfg        (cfg),
    .button_raw (in_ch.button_pressed),
    .power_raw  (in_ch.power_led_on),
    .btn        (btn),
    .green_next (green_next)
  );

  bslc_lock_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_lock_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .btn  (btn),
    .stat (stat)
  );

  bslc_key_pattern u_key_pattern (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .locked         (stat.locked),
    .power_raw      (in_ch.power_led_on),
    .button_stable  (btn.stable),
    .key_level_next (key_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ch.power_key_level <= key_next;
      out_ch.red_led         <= stat.red_led;
      out_ch.locked_flag     <= stat.locked;
      out_ch.green_level     <= green_next;
      out_ch.tap_window      <= stat.window;
      out_ch.taps_seen       <= stat.taps;
    end
  end

endmodule

`default_nettype wire
